// File: rtl/ipv6t_pkg.sv
package ipv6t_pkg;

  localparam int GROUPS = 8;
  localparam int GROUP_W = 16;
  localparam int CHAR_W = 7;

  typedef logic [GROUP_W-1:0] grp_t;
  typedef logic [2:0] gidx_t;
  typedef logic [3:0] glen_t;
  typedef logic [1:0] dig_t;
  typedef logic [CHAR_W-1:0] char_t;

  // Per-group data after the first stage: value, index of the top
  // significant nibble, and zero-run length starting at that group.
  typedef struct packed {
    grp_t  [GROUPS-1:0] grp;
    dig_t  [GROUPS-1:0] top;
    glen_t [GROUPS-1:0] run;
  } scan_t;

  typedef struct packed {
    grp_t [GROUPS-1:0] grp;
    dig_t [GROUPS-1:0] top;
    logic              has_run;
    gidx_t             run_start;
    glen_t             run_len;
  } plan_t;

  localparam char_t CHAR_COLON = 7'h3A;
  localparam char_t CHAR_ZERO  = 7'h30;
  localparam char_t CHAR_A     = 7'h61;

  function automatic char_t hex_char(input logic [3:0] d);
    char_t c;
    if (d >= 4'd10) begin
      c = CHAR_A + {3'b000, d} - 7'd10;
    end else begin
      c = CHAR_ZERO + {3'b000, d};
    end
    return c;
  endfunction

endpackage

// File: rtl/ipv6t_group_scan.sv
module ipv6t_group_scan
  import ipv6t_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  grp_t [GROUPS-1:0] in_grp,
  output logic              out_valid,
  input  logic              out_ready,
  output scan_t             out_data
);

  scan_t scan_next;

  always_comb begin
    glen_t acc;
    acc = '0;
    scan_next.grp = in_grp;
    for (int g = 0; g < GROUPS; g++) begin
      if (in_grp[g][15:12] != 4'd0) begin
        scan_next.top[g] = 2'd3;
      end else if (in_grp[g][11:8] != 4'd0) begin
        scan_next.top[g] = 2'd2;
      end else if (in_grp[g][7:4] != 4'd0) begin
        scan_next.top[g] = 2'd1;
      end else begin
        scan_next.top[g] = 2'd0;
      end
    end
    // zero-run length from each group to the right
    for (int s = GROUPS - 1; s >= 0; s--) begin
      if (in_grp[s] == '0) begin
        acc = acc + 4'd1;
      end else begin
        acc = '0;
      end
      scan_next.run[s] = acc;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= scan_next;
    end
  end

endmodule

// File: rtl/ipv6t_run_find.sv
module ipv6t_run_find
  import ipv6t_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  scan_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output plan_t out_data
);

  plan_t plan_next;

  // leftmost longest run: strict compare keeps the first one on ties
  always_comb begin
    glen_t best_len;
    gidx_t best_start;
    best_len = '0;
    best_start = '0;
    for (int s = 0; s < GROUPS; s++) begin
      if (in_data.run[s] > best_len) begin
        best_len = in_data.run[s];
        best_start = gidx_t'(s);
      end
    end
    plan_next.grp = in_data.grp;
    plan_next.top = in_data.top;
    plan_next.has_run = (best_len >= 4'd2);
    plan_next.run_start = best_start;
    plan_next.run_len = best_len;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= plan_next;
    end
  end

endmodule

// File: rtl/ipv6t_char_emit.sv
module ipv6t_char_emit
  import ipv6t_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  plan_t in_data,
  output logic  m_valid,
  input  logic  m_ready,
  output char_t m_char,
  output logic  m_last
);

  typedef enum logic [1:0] {
    PH_COL1,
    PH_COL2,
    PH_SEP,
    PH_DIG
  } phase_t;

  logic   busy;
  phase_t phase, phase_next;
  gidx_t  grp_i, grp_i_next;
  dig_t   dig, dig_next;
  plan_t  cur;
  char_t  ch;
  logic   ch_last;
  logic   fire, done;
  grp_t   cur_g;
  logic [3:0] nib;
  glen_t  gnext, gskip;

  assign cur_g = cur.grp[grp_i];
  assign nib = cur_g[{dig, 2'b00} +: 4];
  assign gnext = {1'b0, grp_i} + 4'd1;
  assign gskip = {1'b0, grp_i} + cur.run_len;

  always_comb begin
    ch = CHAR_COLON;
    ch_last = 1'b0;
    phase_next = phase;
    grp_i_next = grp_i;
    dig_next = dig;
    unique case (phase)
      PH_COL1: begin
        phase_next = PH_COL2;
      end
      PH_COL2: begin
        ch_last = gskip[3];
        phase_next = PH_DIG;
        grp_i_next = gskip[2:0];
        dig_next = cur.top[gskip[2:0]];
      end
      PH_SEP: begin
        phase_next = PH_DIG;
        dig_next = cur.top[grp_i];
      end
      PH_DIG: begin
        ch = hex_char(nib);
        if (dig != 2'd0) begin
          dig_next = dig - 2'd1;
        end else begin
          ch_last = (grp_i == gidx_t'(GROUPS - 1));
          grp_i_next = gnext[2:0];
          if (cur.has_run && gnext[2:0] == cur.run_start) begin
            phase_next = PH_COL1;
          end else begin
            phase_next = PH_SEP;
          end
        end
      end
      default: begin
        phase_next = PH_DIG;
      end
    endcase
  end

  assign fire = busy && (!m_valid || m_ready);
  assign done = fire && ch_last;
  assign in_ready = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      m_valid <= 1'b0;
      phase <= PH_DIG;
      grp_i <= '0;
      dig <= '0;
    end else begin
      if (!m_valid || m_ready) begin
        m_valid <= fire;
      end
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        grp_i <= '0;
        dig <= in_data.top[0];
        if (in_data.has_run && in_data.run_start == '0) begin
          phase <= PH_COL1;
        end else begin
          phase <= PH_DIG;
        end
      end else begin
        if (done) begin
          busy <= 1'b0;
        end
        if (fire) begin
          phase <= phase_next;
          grp_i <= grp_i_next;
          dig <= dig_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= in_data;
    end
    if (fire) begin
      m_char <= ch;
      m_last <= ch_last;
    end
  end

endmodule

// File: rtl/ipv6_address_to_text_core.sv
// Channel   Dir  Payload                                   Transfer
// s_axis    in   tdata[127:0] = group_0 .. group_7         tvalid && tready
// m_axis    out  tdata[7:0] = text_char, 0; tlast=is_last  tvalid && tready
//
// Two register stages (group scan, run select) feed a character emitter
// with an output register; the first character of an address passes the
// scan and run-select registers, the emitter's address and output registers.
// An address gives 2 to 39 characters, one per cycle unless m_axis stalls.
// rst is synchronous and clears all valid bits and emitter state.
// A stall on m_axis holds every stage; nothing is dropped or repeated.
module ipv6_address_to_text_core
  import ipv6t_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [GROUPS*GROUP_W-1:0]  s_axis_tdata,   // group_0 .. group_7
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,   // text_char, zero pad
  output logic                       m_axis_tlast
);

  grp_t [GROUPS-1:0] in_grp;
  logic  scan_valid, scan_ready;
  scan_t scan_data;
  logic  plan_valid, plan_ready;
  plan_t plan_data;
  char_t out_char;
  logic [5:0] frame_cnt;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      in_grp[g] = s_axis_tdata[g*GROUP_W +: GROUP_W];
    end
  end

  ipv6t_group_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_grp    (in_grp),
    .out_valid (scan_valid),
    .out_ready (scan_ready),
    .out_data  (scan_data)
  );

  ipv6t_run_find u_run (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scan_valid),
    .in_ready  (scan_ready),
    .in_data   (scan_data),
    .out_valid (plan_valid),
    .out_ready (plan_ready),
    .out_data  (plan_data)
  );

  ipv6t_char_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (plan_valid),
    .in_ready (plan_ready),
    .in_data  (plan_data),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_char   (out_char),
    .m_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

  // characters already sent in the current address text
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cnt <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tlast) begin
        frame_cnt <= '0;
      end else begin
        frame_cnt <= frame_cnt + 6'd1;
      end
    end
  end

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[6:0] == CHAR_COLON) ||
      (m_axis_tdata[6:0] >= CHAR_ZERO && m_axis_tdata[6:0] <= 7'h39) ||
      (m_axis_tdata[6:0] >= CHAR_A && m_axis_tdata[6:0] <= 7'h66))
    else $error("non-hex, non-colon character");

  a_text_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> frame_cnt <= 6'd38)
    else $error("address text longer than 39 characters");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
